[rtl/kvl_pkg.sv]
package kvl_pkg;

   localparam int VALUE_W     = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_EVAL   = 2'd2;
   localparam logic [1:0] ACT_NOP    = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] time_stamp;
      logic signed [VALUE_W-1:0] x;
      logic signed [VALUE_W-1:0] y;
      logic signed [VALUE_W-1:0] z;
   } key_type;

   typedef struct packed {
      logic [1:0] action;
      key_type    key;
   } req_type;

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] x;
      logic signed [VALUE_W-1:0] y;
      logic signed [VALUE_W-1:0] z;
      logic [1:0]                status;
      logic [6:0]                key_count;
   } rsp_type;

endpackage

[rtl/keyframe_vector_lerp.sv]
// clear, append, no-op and evaluate on an empty table: response 2 cycles after the request
// evaluate: 3 cycles when the first key decides, 3 + k without a bracketing pair, and
// k + FRACTION_BITS + 11 when it interpolates, k = keys scanned past the first (at most
// MAX_KEYS - 1), set by the one-key-per-cycle table read, the bit-serial divider and one
// shared multiplier; the two-entry request queue accepts while the back end works, busy when full
// rsp_valid strobes once per request, in order, the receiver cannot stall; sync reset empties all
module keyframe_vector_lerp #(
   parameter int MAX_KEYS      = 64,
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_time_stamp,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic signed [31:0] req_in_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_key_count
);
   import kvl_pkg::*;

   req_type req;
   req_type head;
   rsp_type rsp;
   logic    push;
   logic    pop;
   logic    empty;
   logic    full;

   assign req.action         = req_action;
   assign req.key.time_stamp = req_time_stamp;
   assign req.key.x          = req_in_x;
   assign req.key.y          = req_in_y;
   assign req.key.z          = req_in_z;
   assign push               = start && !full;
   assign busy               = full;

   kvl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(req),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   kvl_exec #(
      .MAX_KEYS     (MAX_KEYS),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_exec (
      .clock(clock),
      .reset(reset),
      .head (head),
      .empty(empty),
      .pop  (pop),
      .rsp  (rsp)
   );

   assign rsp_valid     = rsp.valid;
   assign rsp_out_x     = rsp.x;
   assign rsp_out_y     = rsp.y;
   assign rsp_out_z     = rsp.z;
   assign rsp_status    = rsp.status;
   assign rsp_key_count = rsp.key_count;

endmodule

[rtl/kvl_ram.sv]
module kvl_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/kvl_queue.sv]
module kvl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  kvl_pkg::req_type push_data,
   input  logic             pop,
   output kvl_pkg::req_type head,
   output logic             empty,
   output logic             full
);
   import kvl_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (fill_ff == '0);
   assign full  = (fill_ff == CNT_W'(QUEUE_DEPTH));

endmodule

[rtl/kvl_div.sv]
module kvl_div #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            num,
   input  logic [31:0]            den,
   output logic                   done,
   output logic [FRACTION_BITS:0] quot
);

   localparam int CNT_W = $clog2(FRACTION_BITS + 1);

   logic                   run_ff, run_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [32:0]            rem_ff, rem_in;
   logic [31:0]            den_ff, den_in;
   logic [FRACTION_BITS:0] quot_ff, quot_in;
   logic [32:0]            rem_shift;
   logic                   q_bit;
   logic                   first_bit;

   always_comb begin
      first_bit = (num >= den);
      rem_shift = {rem_ff[31:0], 1'b0};
      q_bit     = (rem_shift >= {1'b0, den_ff});
      run_in    = run_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quot_in   = quot_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = CNT_W'(FRACTION_BITS);
         den_in  = den;
         quot_in = (FRACTION_BITS+1)'(first_bit);
         rem_in  = first_bit ? {1'b0, num - den} : {1'b0, num};
      end else if (run_ff && cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         quot_in = {quot_ff[FRACTION_BITS-1:0], q_bit};
         rem_in  = q_bit ? rem_shift - {1'b0, den_ff} : rem_shift;
      end else if (run_ff) begin
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = run_ff && (cnt_ff == '0);
   assign quot = quot_ff;

endmodule

[rtl/kvl_exec.sv]
module kvl_exec #(
   parameter int MAX_KEYS      = 64,
   parameter int FRACTION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  kvl_pkg::req_type head,
   input  logic             empty,
   output logic             pop,
   output kvl_pkg::rsp_type rsp
);
   import kvl_pkg::*;

   localparam int AW     = $clog2(MAX_KEYS);
   localparam int CW     = $clog2(MAX_KEYS + 1);
   localparam int PROD_W = FRACTION_BITS + 35;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FIRST  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DSTART = 3'd3;
   localparam logic [2:0] S_DWAIT  = 3'd4;
   localparam logic [2:0] S_MUL    = 3'd5;
   localparam logic [2:0] S_ADD    = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      valid_ff, valid_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic signed [31:0]        tq_ff, tq_in;
   key_type                   prev_ff, prev_in;
   logic signed [31:0]        a_ff [3];
   logic signed [31:0]        a_in [3];
   logic signed [32:0]        diff_ff [3];
   logic signed [32:0]        diff_in [3];
   logic signed [31:0]        res_ff [3];
   logic signed [31:0]        res_in [3];
   logic [31:0]               num_ff, num_in;
   logic [31:0]               den_ff, den_in;
   logic [FRACTION_BITS:0]    t_ff, t_in;
   logic [1:0]                lane_ff, lane_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [1:0]                status_ff, status_in;

   logic                      wr_en;
   logic [AW-1:0]             rd_addr;
   logic [$bits(key_type)-1:0] rd_data;
   key_type                   cur;
   logic                      hit;
   logic                      div_start;
   logic                      div_done;
   logic [FRACTION_BITS:0]    div_quot;
   logic [CW+6:0]             count_ext;

   kvl_ram #(
      .WIDTH($bits(key_type)),
      .DEPTH(MAX_KEYS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(head.key),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   kvl_div #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (num_ff),
      .den  (den_ff),
      .done (div_done),
      .quot (div_quot)
   );

   assign cur = key_type'(rd_data);
   assign hit = ($signed(prev_ff.time_stamp) <= tq_ff) && (tq_ff <= $signed(cur.time_stamp));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      valid_in  = 1'b0;
      idx_in    = idx_ff;
      tq_in     = tq_ff;
      prev_in   = prev_ff;
      a_in      = a_ff;
      diff_in   = diff_ff;
      res_in    = res_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      t_in      = t_ff;
      lane_in   = lane_ff;
      prod_in   = prod_ff;
      status_in = status_ff;
      pop       = 1'b0;
      wr_en     = 1'b0;
      div_start = 1'b0;
      rd_addr   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               status_in = STATUS_OK;
               res_in    = '{3{32'sd0}};
               unique case (head.action)
                  ACT_CLEAR: begin
                     count_in = '0;
                     valid_in = 1'b1;
                  end
                  ACT_APPEND: begin
                     if (count_ff >= CW'(MAX_KEYS)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     valid_in = 1'b1;
                  end
                  ACT_EVAL: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        valid_in  = 1'b1;
                     end else begin
                        tq_in    = head.key.time_stamp;
                        state_in = S_FIRST;
                     end
                  end
                  ACT_NOP: begin
                     valid_in = 1'b1;
                  end
                  default: begin
                     valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_FIRST: begin
            rd_addr = AW'(1);
            if (count_ff == CW'(1) || tq_ff <= $signed(cur.time_stamp)) begin
               res_in   = '{cur.x, cur.y, cur.z};
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               prev_in  = cur;
               idx_in   = AW'(1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_addr = AW'(idx_ff + 1'b1);
            if (hit) begin
               num_in   = 32'(tq_ff - prev_ff.time_stamp);
               den_in   = 32'(cur.time_stamp - prev_ff.time_stamp);
               a_in     = '{prev_ff.x, prev_ff.y, prev_ff.z};
               diff_in[0] = $signed({cur.x[31], cur.x}) - $signed({prev_ff.x[31], prev_ff.x});
               diff_in[1] = $signed({cur.y[31], cur.y}) - $signed({prev_ff.y[31], prev_ff.y});
               diff_in[2] = $signed({cur.z[31], cur.z}) - $signed({prev_ff.z[31], prev_ff.z});
               state_in = S_DSTART;
            end else if (CW'(idx_ff) == count_ff - CW'(1)) begin
               res_in   = '{cur.x, cur.y, cur.z};
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               prev_in = cur;
               idx_in  = idx_ff + 1'b1;
            end
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               t_in     = (den_ff == '0) ? '0 : div_quot;
               lane_in  = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = diff_ff[lane_ff] * $signed({1'b0, t_ff});
            state_in = S_ADD;
         end
         S_ADD: begin
            res_in[lane_ff] = a_ff[lane_ff] + $signed(prod_ff[FRACTION_BITS+31:FRACTION_BITS]);
            if (lane_ff == 2'd2) begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               lane_in  = lane_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      tq_ff     <= tq_in;
      prev_ff   <= prev_in;
      a_ff      <= a_in;
      diff_ff   <= diff_in;
      res_ff    <= res_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      t_ff      <= t_in;
      lane_ff   <= lane_in;
      prod_ff   <= prod_in;
      status_ff <= status_in;
   end

   assign count_ext     = {7'd0, count_ff};
   assign rsp.valid     = valid_ff;
   assign rsp.x         = res_ff[0];
   assign rsp.y         = res_ff[1];
   assign rsp.z         = res_ff[2];
   assign rsp.status    = status_ff;
   assign rsp.key_count = count_ext[6:0];

endmodule

[rtl/kvl_checker.sv]
module kvl_checker #(
   parameter int MAX_KEYS = 64
) (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic signed [31:0] rsp_out_z,
   input logic [1:0]         rsp_status,
   input logic [6:0]         rsp_key_count
);
   import kvl_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("response or busy right after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_out_x == 32'sd0 && rsp_out_y == 32'sd0 && rsp_out_z == 32'sd0)
      else $error("error response carries nonzero value");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_key_count == 7'(MAX_KEYS))
      else $error("full status with table not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_key_count == 7'd0)
      else $error("empty status with keys held");

endmodule

bind keyframe_vector_lerp kvl_checker #(.MAX_KEYS(MAX_KEYS)) u_kvl_checker (.*);
